FILE: src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: src/uss_pkg.sv
// Package with constants and types of the UTF-8 stream sanitizer.
`timescale 1ns / 1ps
package uss_pkg;

   localparam logic [7:0] ByteTab       = 8'h09;
   localparam logic [7:0] ByteNewline   = 8'h0A;
   localparam logic [7:0] PrintLow      = 8'h20;
   localparam logic [7:0] PrintEnd      = 8'h7F;
   localparam logic [7:0] AsciiEnd      = 8'h80;
   localparam logic [7:0] ContMask      = 8'hC0;
   localparam logic [7:0] ContPattern   = 8'h80;
   localparam logic [7:0] LeadLow       = 8'hC2;
   localparam logic [7:0] LeadThree     = 8'hE0;
   localparam logic [7:0] LeadFour      = 8'hF0;
   localparam logic [7:0] LeadEnd       = 8'hF5;
   localparam logic [7:0] SurrogateLead = 8'hED;
   localparam logic [7:0] SurrogateLow  = 8'hA0;

   localparam logic [15:0] CapacityReset = 16'd256;
   localparam logic        RegCapacity   = 1'b0;
   localparam int          QueueDepthDefault = 4;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
      logic            has_data;
      logic            eos;
      logic [15:0]     base;
   } group_type;

endpackage

FILE: src/utf8_stream_sanitizer.sv
// Top level of the UTF-8 stream sanitizer with its register port.
//
//   Channel  Direction  Handshake          Carries
//   req      in         req_valid/ready    one raw byte and its last flag
//   rsp      out        rsp_valid/ready    one cleaned byte or end-only word
//   csr      in/out     psel/penable       capacity register at address 0
//
// A byte is taken every cycle while the group queue has room.
// Each accepted byte yields zero to four words, one per cycle if rsp_ready.
// An accepted byte goes into a queue slot, then into the output register.
// Reset clears all control state and sets capacity to 256; no clearing pass.
// Either side may stall; the group queue absorbs the difference.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module utf8_stream_sanitizer #(
   parameter int QueueDepth = uss_pkg::QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_end_of_string,
   output logic [15:0] rsp_out_count,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [15:0]        capacity_ff, capacity_in;
   logic               space_ok;
   logic               push_valid;
   uss_pkg::group_type push_data;
   logic               pop_valid;
   logic               pop;
   uss_pkg::group_type pop_data;

   assign pready    = 1'b1;
   assign req_ready = space_ok;

   always_comb begin
      capacity_in = capacity_ff;
      if (psel && penable && pwrite && (paddr[2] == uss_pkg::RegCapacity)) begin
         capacity_in = pwdata[15:0];
      end
      prdata = (paddr[2] == uss_pkg::RegCapacity) ? {16'd0, capacity_ff} : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= uss_pkg::CapacityReset;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   uss_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .space_ok   (space_ok),
      .in_byte    (req_in_byte),
      .in_last    (req_in_last),
      .capacity   (capacity_ff),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   uss_queue #(.Depth(QueueDepth)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .space_ok   (space_ok),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_data   (pop_data)
   );

   uss_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_data          (pop_data),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_end_of_string (rsp_end_of_string),
      .rsp_out_count     (rsp_out_count)
   );

   // An end-only word always closes its string.
   `ASSERT_IMPLIES(a_end_only_closes, clock, reset, rsp_valid && !rsp_byte_valid, rsp_end_of_string)
   // A data word counts itself, so its count is never zero.
   `ASSERT_IMPLIES(a_count_nonzero, clock, reset, rsp_valid && rsp_byte_valid, rsp_out_count != 0)
   // An end-only word carries no byte.
   `ASSERT_IMPLIES(a_end_only_zero, clock, reset, rsp_valid && !rsp_byte_valid, rsp_out_byte == 0)

endmodule

FILE: src/uss_front.sv
// Front end: accepts bytes, tracks pending characters and forms result groups.
`timescale 1ns / 1ps
module uss_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               space_ok,
   input  logic [7:0]         in_byte,
   input  logic               in_last,
   input  logic [15:0]        capacity,
   output logic               push_valid,
   output uss_pkg::group_type push_data
);

   logic [2:0][7:0] held_ff, held_in;
   logic [1:0]      held_cnt_ff, held_cnt_in;
   logic [2:0]      exp_ff, exp_in;
   logic [15:0]     wc_ff, wc_in;
   logic            ended_ff, ended_in;
   logic [2:0]      emit_n;
   logic            multi;
   logic            accept;

   assign accept = req_valid && space_ok;

   always_comb begin
      logic restart;
      logic cont;
      logic surr;
      logic ok;
      logic [16:0] cap17;
      logic [16:0] wc17;
      restart     = 1'b0;
      cont        = (in_byte & uss_pkg::ContMask) == uss_pkg::ContPattern;
      surr        = (held_cnt_ff == 2'd1) && (held_ff[0] == uss_pkg::SurrogateLead) &&
                    (in_byte >= uss_pkg::SurrogateLow);
      ok          = (in_byte == uss_pkg::ByteNewline) || (in_byte == uss_pkg::ByteTab) ||
                    ((in_byte >= uss_pkg::PrintLow) && (in_byte < uss_pkg::PrintEnd));
      cap17       = {1'b0, capacity};
      wc17        = {1'b0, wc_ff};
      held_in     = held_ff;
      held_cnt_in = held_cnt_ff;
      exp_in      = exp_ff;
      wc_in       = wc_ff;
      ended_in    = ended_ff;
      emit_n      = 3'd0;
      multi       = 1'b0;
      if (!ended_ff) begin
         if (in_byte == 8'd0) begin
            ended_in    = 1'b1;
            held_cnt_in = 2'd0;
            exp_in      = 3'd0;
         end else begin
            restart = 1'b1;
            if (held_cnt_ff != 2'd0) begin
               held_cnt_in = 2'd0;
               exp_in      = 3'd0;
               if (cont && !surr) begin
                  restart = 1'b0;
                  if ({1'b0, held_cnt_ff} + 3'd1 == exp_ff) begin
                     if (wc17 + {14'd0, exp_ff} < cap17) begin
                        emit_n = exp_ff;
                        multi  = 1'b1;
                        wc_in  = wc_ff + {13'd0, exp_ff};
                     end
                  end else if (held_cnt_ff != 2'd3) begin
                     held_in[held_cnt_ff] = in_byte;
                     held_cnt_in          = held_cnt_ff + 2'd1;
                     exp_in               = exp_ff;
                  end
               end
            end
            if (restart) begin
               if (in_byte < uss_pkg::AsciiEnd) begin
                  if (ok && (wc17 + 17'd1 < cap17)) begin
                     emit_n = 3'd1;
                     wc_in  = wc_ff + 16'd1;
                  end
               end else if ((in_byte >= uss_pkg::LeadLow) && (in_byte < uss_pkg::LeadEnd)) begin
                  held_in[0]  = in_byte;
                  held_cnt_in = 2'd1;
                  if (in_byte < uss_pkg::LeadThree) begin
                     exp_in = 3'd2;
                  end else if (in_byte < uss_pkg::LeadFour) begin
                     exp_in = 3'd3;
                  end else begin
                     exp_in = 3'd4;
                  end
               end
            end
         end
      end
      if (in_last) begin
         held_cnt_in = 2'd0;
         exp_in      = 3'd0;
         wc_in       = 16'd0;
         ended_in    = 1'b0;
      end
   end

   always_comb begin
      push_data.bytes[0] = multi ? held_ff[0] : in_byte;
      push_data.bytes[1] = (held_cnt_ff > 2'd1) ? held_ff[1] : in_byte;
      push_data.bytes[2] = (held_cnt_ff > 2'd2) ? held_ff[2] : in_byte;
      push_data.bytes[3] = in_byte;
      push_data.has_data = emit_n != 3'd0;
      push_data.last_idx = (emit_n != 3'd0) ? 2'(emit_n - 3'd1) : 2'd0;
      push_data.eos      = in_last;
      push_data.base     = wc_ff;
      push_valid         = accept && ((emit_n != 3'd0) || in_last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_cnt_ff <= 2'd0;
         exp_ff      <= 3'd0;
         wc_ff       <= 16'd0;
         ended_ff    <= 1'b0;
      end else if (accept) begin
         held_cnt_ff <= held_cnt_in;
         exp_ff      <= exp_in;
         wc_ff       <= wc_in;
         ended_ff    <= ended_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

FILE: src/uss_queue.sv
// Short queue of result groups between the front and back ends.
`timescale 1ns / 1ps
module uss_queue #(
   parameter int Depth = uss_pkg::QueueDepthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  uss_pkg::group_type push_data,
   output logic               space_ok,
   output logic               pop_valid,
   input  logic               pop,
   output uss_pkg::group_type pop_data
);

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] CntFull = CntWidth'(Depth);
   localparam logic [PtrWidth-1:0] PtrOne  = PtrWidth'(1);
   localparam logic [CntWidth-1:0] CntOne  = CntWidth'(1);

   uss_pkg::group_type slots_ff [Depth];
   logic [PtrWidth-1:0] wr_ff, wr_in;
   logic [PtrWidth-1:0] rd_ff, rd_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                do_push;
   logic                do_pop;

   assign space_ok  = cnt_ff != CntFull;
   assign pop_valid = cnt_ff != '0;
   assign pop_data  = slots_ff[rd_ff];
   assign do_push   = push_valid && space_ok;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_in  = do_push ? ((wr_ff == PtrLast) ? '0 : wr_ff + PtrOne) : wr_ff;
      rd_in  = do_pop ? ((rd_ff == PtrLast) ? '0 : rd_ff + PtrOne) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CntOne;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CntOne;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ff] <= push_data;
      end
   end

endmodule

FILE: src/uss_back.sv
// Back end: unrolls each result group into words on the output register.
`timescale 1ns / 1ps
module uss_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   input  uss_pkg::group_type pop_data,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_byte_valid,
   output logic               rsp_end_of_string,
   output logic [15:0]        rsp_out_count
);

   logic [1:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        bv_ff, bv_in;
   logic        eos_ff, eos_in;
   logic [15:0] count_ff, count_in;
   logic        load;
   logic        done;

   assign load = pop_valid && (!valid_ff || rsp_ready);
   assign done = idx_ff == pop_data.last_idx;
   assign pop  = load && done;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_ready;
      byte_in  = byte_ff;
      bv_in    = bv_ff;
      eos_in   = eos_ff;
      count_in = count_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = done ? 2'd0 : idx_ff + 2'd1;
         bv_in    = pop_data.has_data;
         eos_in   = pop_data.eos && done;
         byte_in  = pop_data.has_data ? pop_data.bytes[idx_ff] : 8'd0;
         count_in = pop_data.has_data ? pop_data.base + {14'd0, idx_ff} + 16'd1
                                      : pop_data.base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      bv_ff    <= bv_in;
      eos_ff   <= eos_in;
      count_ff <= count_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_byte_valid    = bv_ff;
   assign rsp_end_of_string = eos_ff;
   assign rsp_out_count     = count_ff;

endmodule
